[rtl/rau_pkg.sv]
// Package: shared types, command codes and status codes of the rational arithmetic unit.
package rau_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int OP_W = OPERAND_BITS;
    localparam int RAW_W = 2 * OP_W + 2;
    localparam int RES_W = 32;

    typedef enum logic [2:0] {
        CMD_REDUCE = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_ADDS   = 3'd2,
        CMD_MUL    = 3'd3,
        CMD_DIV    = 3'd4,
        CMD_SOVB   = 3'd5,
        CMD_AOVS   = 3'd6,
        CMD_EQ     = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_GCD0 = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic signed [OP_W-1:0] a_num;
        logic signed [OP_W-1:0] a_den;
        logic signed [OP_W-1:0] b_num;
        logic signed [OP_W-1:0] b_den;
        logic signed [OP_W-1:0] scalar;
    } req_t;

    typedef struct packed {
        logic signed [RES_W-1:0] res_num;
        logic signed [RES_W-1:0] res_den;
        logic                    is_equal;
        status_t                 status;
    } rsp_t;

    // Raw fraction handed from the front part to the back part.
    typedef struct packed {
        logic signed [RAW_W-1:0] n;
        logic signed [RAW_W-1:0] d;
        logic                    is_cmp;
        logic                    is_equal;
        logic                    ovf;
    } raw_t;

endpackage

[rtl/rau_front.sv]
// Front part: forms the raw numerator and denominator of one request, products first, then the sum.
module rau_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rau_pkg::req_t req,
    output logic          raw_valid,
    input  logic          raw_ready,
    output rau_pkg::raw_t raw
);
    localparam int OW = rau_pkg::OP_W;
    localparam int PW = 2 * OW;
    localparam int RW = rau_pkg::RAW_W;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM, S_OUT} state_t;

    state_t                  state_reg;
    rau_pkg::req_t           req_reg;
    logic signed [PW-1:0]    m0_reg, m1_reg, m2_reg;
    rau_pkg::raw_t           raw_reg;

    logic signed [OW-1:0] an, ad, bn, bd, sc;
    logic signed [PW-1:0] p0, p1, p2;
    logic signed [PW:0]   sum;
    rau_pkg::raw_t        raw_next;

    assign an = req_reg.a_num;
    assign ad = req_reg.a_den;
    assign bn = req_reg.b_num;
    assign bd = req_reg.b_den;
    assign sc = req_reg.scalar;

    // Three products, formed in parallel; each has its own multiplier and register.
    always_comb
    begin
        p0 = PW'(an) * PW'(bd);
        p1 = PW'(bn) * PW'(ad);
        p2 = PW'(ad) * PW'(bd);
        unique case (req_reg.cmd)
            rau_pkg::CMD_ADDS:
            begin
                p0 = PW'(an);
                p1 = PW'(sc) * PW'(ad);
                p2 = PW'(ad);
            end
            rau_pkg::CMD_MUL:
            begin
                p0 = PW'(an) * PW'(bn);
            end
            rau_pkg::CMD_DIV:
            begin
                p2 = PW'(ad) * PW'(bn);
            end
            rau_pkg::CMD_SOVB:
            begin
                p0 = PW'(sc) * PW'(bd);
                p2 = PW'(bn);
            end
            rau_pkg::CMD_AOVS:
            begin
                p0 = PW'(an);
                p2 = PW'(ad) * PW'(sc);
            end
            default:
            begin
            end
        endcase
    end

    assign sum = (PW+1)'(m0_reg) + (PW+1)'(m1_reg);

    always_comb
    begin
        raw_next          = '0;
        raw_next.is_cmp   = (req_reg.cmd == rau_pkg::CMD_EQ);
        raw_next.is_equal = raw_next.is_cmp && (an == bn) && (ad == bd);
        raw_next.n        = RW'(m0_reg);
        raw_next.d        = RW'(m2_reg);
        unique case (req_reg.cmd)
            rau_pkg::CMD_ADD:
            begin
                if (ad == bd)
                begin
                    raw_next.n = RW'(an) + RW'(bn);
                    raw_next.d = RW'(ad);
                end
                else
                begin
                    raw_next.n = RW'(sum);
                end
            end
            rau_pkg::CMD_ADDS:
            begin
                raw_next.n = RW'(sum);
            end
            rau_pkg::CMD_REDUCE:
            begin
                raw_next.n = RW'(an);
                raw_next.d = RW'(ad);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            req_reg   <= '0;
            m0_reg    <= '0;
            m1_reg    <= '0;
            m2_reg    <= '0;
            raw_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= req;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    m0_reg    <= p0;
                    m1_reg    <= p1;
                    m2_reg    <= p2;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    raw_reg   <= raw_next;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (raw_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign raw_valid = (state_reg == S_OUT);
    assign raw       = raw_reg;

endmodule

[rtl/rau_queue.sv]
// Two-entry queue that decouples the front part from the back part.
module rau_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rau_pkg::raw_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rau_pkg::raw_t out_data
);
    rau_pkg::raw_t mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= in_data;
    end

endmodule

[rtl/rau_back.sv]
// Back part: Euclid gcd and exact division by the gcd, both bit-serial.
module rau_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          raw_valid,
    output logic          raw_ready,
    input  rau_pkg::raw_t raw,
    output logic          done,
    output rau_pkg::rsp_t rsp
);
    localparam int RW = rau_pkg::RAW_W;
    localparam int CW = $clog2(RW + 1);

    typedef enum logic [2:0] {S_IDLE, S_GCD_START, S_DIV, S_GCD_STEP, S_QN, S_QD, S_DONE}
        state_t;

    state_t                 state_reg;
    rau_pkg::raw_t          raw_reg;
    logic signed [RW-1:0]   x_reg, y_reg;
    logic [RW-1:0]          dvd_reg, dvs_reg, rem_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   qneg_reg;
    logic [RW-1:0]          gabs_reg;
    logic signed [RW-1:0]   qn_reg;
    rau_pkg::rsp_t          rsp_reg;
    logic                   done_reg;

    logic [RW:0]            trial;
    logic [RW-1:0]          rem_sh;
    logic signed [RW-1:0]   q_signed, qd_fin;
    logic                   qn_ok, qd_ok;

    // One restoring division step per cycle on magnitudes.
    assign rem_sh = {rem_reg[RW-2:0], dvd_reg[RW-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, dvs_reg};
    assign q_signed = qneg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);
    assign qd_fin   = q_signed;
    assign qn_ok = ($signed(qn_reg) >= -(RW'(1) <<< (rau_pkg::RES_W-1)))
                && ($signed(qn_reg) <= $signed((RW'(1) << (rau_pkg::RES_W-1)) - RW'(1)));
    assign qd_ok = ($signed(qd_fin) >= -(RW'(1) <<< (rau_pkg::RES_W-1)))
                && ($signed(qd_fin) <= $signed((RW'(1) << (rau_pkg::RES_W-1)) - RW'(1)));

    function automatic logic [RW-1:0] mag(input logic signed [RW-1:0] v);
        return v[RW-1] ? RW'(-v) : RW'(v);
    endfunction

    // Result with zero fraction fields.
    function automatic rau_pkg::rsp_t make_rsp(input logic eq, input rau_pkg::status_t st);
        rau_pkg::rsp_t r;
        r          = '0;
        r.is_equal = eq;
        r.status   = st;
        return r;
    endfunction

    assign raw_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (raw_valid)
                    begin
                        raw_reg <= raw;
                        x_reg   <= raw.n;
                        y_reg   <= raw.d;
                        state_reg <= S_GCD_START;
                    end
                end
                S_GCD_START:
                begin
                    if (raw_reg.is_cmp)
                    begin
                        rsp_reg   <= make_rsp(raw_reg.is_equal, rau_pkg::ST_OK);
                        state_reg <= S_DONE;
                    end
                    else if (raw_reg.ovf)
                    begin
                        rsp_reg   <= make_rsp(1'b0, rau_pkg::ST_OVF);
                        state_reg <= S_DONE;
                    end
                    else if (y_reg == '0)
                    begin
                        // x is the gcd; start dividing n by it.
                        if (x_reg == '0)
                        begin
                            rsp_reg   <= make_rsp(1'b0, rau_pkg::ST_GCD0);
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            gabs_reg <= mag(x_reg);
                            dvd_reg  <= mag(raw_reg.n);
                            dvs_reg  <= mag(x_reg);
                            qneg_reg <= raw_reg.n[RW-1] ^ x_reg[RW-1];
                            rem_reg  <= '0;
                            cnt_reg  <= CW'(RW);
                            state_reg <= S_QN;
                        end
                    end
                    else
                    begin
                        // Remainder x % y, sign follows x.
                        dvd_reg  <= mag(x_reg);
                        dvs_reg  <= mag(y_reg);
                        qneg_reg <= x_reg[RW-1];
                        rem_reg  <= '0;
                        cnt_reg  <= CW'(RW);
                        state_reg <= S_DIV;
                    end
                end
                S_DIV, S_QN, S_QD:
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                        if (!trial[RW])
                        begin
                            rem_reg <= trial[RW-1:0];
                            dvd_reg <= {dvd_reg[RW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            dvd_reg <= {dvd_reg[RW-2:0], 1'b0};
                        end
                    end
                    else if (state_reg == S_DIV)
                    begin
                        x_reg <= y_reg;
                        y_reg <= qneg_reg ? -$signed(rem_reg) : $signed(rem_reg);
                        state_reg <= S_GCD_START;
                    end
                    else if (state_reg == S_QN)
                    begin
                        qn_reg   <= q_signed;
                        dvd_reg  <= mag(raw_reg.d);
                        dvs_reg  <= gabs_reg;
                        qneg_reg <= raw_reg.d[RW-1] ^ x_reg[RW-1];
                        rem_reg  <= '0;
                        cnt_reg  <= CW'(RW);
                        state_reg <= S_QD;
                    end
                    else
                    begin
                        if (qn_ok && qd_ok)
                        begin
                            rsp_reg <= {qn_reg[rau_pkg::RES_W-1:0],
                                        qd_fin[rau_pkg::RES_W-1:0],
                                        1'b0, rau_pkg::ST_OK};
                        end
                        else
                        begin
                            rsp_reg <= make_rsp(1'b0, rau_pkg::ST_OVF);
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_DONE)) else $error("result without finish");
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.is_equal |-> rsp.res_num == '0 && rsp.res_den == '0)
        else $error("compare result not zero");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != rau_pkg::ST_OK |-> rsp.res_num == '0)
        else $error("error result not zero");

endmodule

[rtl/rational_arithmetic_unit.sv]
// Top level: rational arithmetic unit with gcd reduction.
// Usage:
//   Drive cmd and the operands on req and raise start. The request is taken
//   at a clock edge where start is high and busy is low.
//   The front part forms the raw fraction with its own multipliers,
//   registering the products and then the sum, and hands it through a
//   two-entry queue to the back part. The back part runs Euclid's
//   algorithm with a bit-serial divider: each remainder is one division,
//   and after the last remainder n and d are each divided exactly by the
//   gcd; a compare skips the divider. The back part takes a new raw
//   fraction only once it is idle again, so it works on one at a time.
//   Each result appears on rsp for exactly one cycle with done high; the
//   receiver cannot stall, so nothing holds the back part.
//   Reset (rst_n low) drops all requests in flight and empties the queue.
//   The front part accepts a new request once it has handed the previous one
//   to the queue, which needs room in the queue.
module rational_arithmetic_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rau_pkg::req_t req,
    output logic          done,
    output rau_pkg::rsp_t rsp
);
    rau_pkg::raw_t f_raw, q_raw;
    logic          f_valid, f_ready, q_valid, q_ready;

    // Classify and form the raw fraction.
    rau_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .raw_valid(f_valid), .raw_ready(f_ready), .raw(f_raw)
    );

    // Hold raw fractions while the back part is reducing.
    rau_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_raw),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_raw)
    );

    // Reduce by the gcd.
    rau_back u_back (
        .clk(clk), .rst_n(rst_n),
        .raw_valid(q_valid), .raw_ready(q_ready), .raw(q_raw),
        .done(done), .rsp(rsp)
    );

endmodule

[dv/rational_arithmetic_unit_test.sv]
// Testbench for the rational arithmetic unit: queue-fed driver, monitor, fraction predictor.
`timescale 1ns / 1ps

module rational_arithmetic_unit_test;

    localparam int N_RANDOM    = 1500;
    localparam int CYCLE_LIMIT = 20000000;
    localparam int DRAIN_WAIT  = 4000;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    rau_pkg::req_t  req;
    logic           done;
    rau_pkg::rsp_t  rsp;

    rau_pkg::req_t  pending_reqs[$];
    rau_pkg::rsp_t  expected_rsps[$];
    int    n_total;
    int    n_sent;
    int    n_errors;
    int    n_cycles;
    int    sender_idle_pct;

    rational_arithmetic_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Euclid with truncating remainder; a divisor of -1 always leaves remainder 0.
    function automatic longint gcd_trunc(longint x, longint y);
        longint r;
        while (y != 0)
        begin
            r = (y == -1) ? 64'sd0 : x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    // Form the raw fraction for the command, then reduce it by its gcd.
    function automatic rau_pkg::rsp_t reduce_fraction(rau_pkg::req_t r);
        rau_pkg::rsp_t o;
        longint an, ad, bn, bd, sc, n, d, g, qn, qd;
        an = r.a_num;
        ad = r.a_den;
        bn = r.b_num;
        bd = r.b_den;
        sc = r.scalar;
        n  = 0;
        d  = 0;
        o  = '0;
        o.status = rau_pkg::ST_OK;
        case (r.cmd)
            rau_pkg::CMD_REDUCE: begin n = an; d = ad; end
            rau_pkg::CMD_ADD:
            begin
                if (ad == bd)
                begin
                    n = an + bn;
                    d = ad;
                end
                else
                begin
                    n = an * bd + bn * ad;
                    d = ad * bd;
                end
            end
            rau_pkg::CMD_ADDS:
            begin
                // Operands are 16 bits, so these sums never leave 64 bits.
                if (ad == 1)
                begin
                    n = an + sc;
                    d = 1;
                end
                else
                begin
                    n = an + sc * ad;
                    d = ad;
                end
            end
            rau_pkg::CMD_MUL:  begin n = an * bn; d = ad * bd; end
            rau_pkg::CMD_DIV:  begin n = an * bd; d = ad * bn; end
            rau_pkg::CMD_SOVB: begin n = sc * bd; d = bn; end
            rau_pkg::CMD_AOVS: begin n = an; d = ad * sc; end
            default:  o.is_equal = (an == bn) && (ad == bd);
        endcase
        if (r.cmd != rau_pkg::CMD_EQ)
        begin
            g = gcd_trunc(n, d);
            if (g == 0)
                o.status = rau_pkg::ST_GCD0;
            else
            begin
                qn = (g == -1) ? -n : n / g;
                qd = (g == -1) ? -d : d / g;
                if (qn < -64'sd2147483648 || qn > 64'sd2147483647 ||
                    qd < -64'sd2147483648 || qd > 64'sd2147483647)
                    o.status = rau_pkg::ST_OVF;
                else
                begin
                    o.res_num = qn[31:0];
                    o.res_den = qd[31:0];
                end
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic rau_pkg::req_t make_req(rau_pkg::cmd_t c, int an, int ad, int bn,
                                               int bd, int sc);
        rau_pkg::req_t r;
        r.cmd    = c;
        r.a_num  = an[15:0];
        r.a_den  = ad[15:0];
        r.b_num  = bn[15:0];
        r.b_den  = bd[15:0];
        r.scalar = sc[15:0];
        return r;
    endfunction

    // Pick an operand: often small so reductions and zero cases show up,
    // sometimes the extremes, otherwise the full range.
    function automatic logic [15:0] rand_operand();
        int k;
        k = $urandom_range(9);
        if (k < 4)
            return 16'($signed($urandom_range(24)) - 12);
        if (k == 4)
            return ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
        return 16'($urandom);
    endfunction

    // Driver: hold a request until it is taken, then advance the queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req   <= '0;
        end
        else
        begin
            logic hold;
            hold = 1'b0;
            if (start && !busy)
            begin
                expected_rsps.push_back(reduce_fraction(req));
                n_sent++;
            end
            else if (start)
                hold = 1'b1;
            sender_idle_pct = (n_sent < n_total / 3) ? 7 :
                              (n_sent < 2 * n_total / 3) ? 65 : 0;
            if (!hold)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    req   <= pending_reqs.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result must match the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("unexpected result (t=%0t)", $realtime);
                n_errors++;
            end
            else
            begin
                rau_pkg::rsp_t want;
                want = expected_rsps.pop_front();
                if (rsp.res_num !== want.res_num)
                    report_mismatch("res_num", rsp.res_num, want.res_num);
                if (rsp.res_den !== want.res_den)
                    report_mismatch("res_den", rsp.res_den, want.res_den);
                if (rsp.is_equal !== want.is_equal)
                    report_mismatch("is_equal", rsp.is_equal, want.is_equal);
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rau_pkg::req_t r;
        n_sent   = 0;
        n_errors = 0;
        n_cycles = 0;
        rst_n    = 1'b0;

        // Directed requests: extremes, every command, the special cases.
        pending_reqs.push_back(make_req(rau_pkg::CMD_REDUCE, 6, -4, 0, 0, 0));
        pending_reqs.push_back(make_req(rau_pkg::CMD_REDUCE, 0, 0, 0, 0, 0));  // gcd zero
        pending_reqs.push_back(make_req(rau_pkg::CMD_REDUCE, -32768, -32768, 0, 0, 0));
        pending_reqs.push_back(make_req(rau_pkg::CMD_REDUCE, 32767, -1, 0, 0, 0));
        pending_reqs.push_back(make_req(rau_pkg::CMD_REDUCE, 0, 5, 0, 0, 0));
        pending_reqs.push_back(make_req(rau_pkg::CMD_ADD, 1, 3, 2, 3, 0));  // equal denominators
        pending_reqs.push_back(make_req(rau_pkg::CMD_ADD, 1, 2, -1, 3, 0));
        pending_reqs.push_back(make_req(rau_pkg::CMD_ADD, -32768, -32768, 32767, 32767, 0));
        pending_reqs.push_back(make_req(rau_pkg::CMD_ADD, 3, 0, -3, 0, 0));
        pending_reqs.push_back(make_req(rau_pkg::CMD_ADDS, 5, 1, -32768, 0, -32768));
        pending_reqs.push_back(make_req(rau_pkg::CMD_ADDS, 5, 7, 0, 0, 32767));
        pending_reqs.push_back(make_req(rau_pkg::CMD_ADDS, 0, 0, 0, 0, 9));
        pending_reqs.push_back(make_req(rau_pkg::CMD_MUL, -32768, -32768, -32768, -32768, 0));
        pending_reqs.push_back(make_req(rau_pkg::CMD_MUL, 4, 6, 9, -10, 0));
        pending_reqs.push_back(make_req(rau_pkg::CMD_DIV, 2, 3, 0, 5, 0));
        pending_reqs.push_back(make_req(rau_pkg::CMD_DIV, 32767, -32768, -32768, 32767, 0));
        pending_reqs.push_back(make_req(rau_pkg::CMD_SOVB, 0, 0, -6, 4, -32768));
        pending_reqs.push_back(make_req(rau_pkg::CMD_SOVB, 0, 0, 0, 0, 3));
        pending_reqs.push_back(make_req(rau_pkg::CMD_AOVS, 7, 3, 0, 0, 0));
        pending_reqs.push_back(make_req(rau_pkg::CMD_AOVS, -32768, -32768, 0, 0, -32768));
        pending_reqs.push_back(make_req(rau_pkg::CMD_EQ, 2, 4, 2, 4, 0));
        pending_reqs.push_back(make_req(rau_pkg::CMD_EQ, 2, 4, 1, 2, 0));  // unreduced, not equal
        pending_reqs.push_back(make_req(rau_pkg::CMD_EQ, -32768, 32767, -32768, 32767, 0));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            r.cmd    = rau_pkg::cmd_t'($urandom_range(7));
            r.a_num  = rand_operand();
            r.a_den  = rand_operand();
            r.b_num  = rand_operand();
            r.b_den  = rand_operand();
            r.scalar = rand_operand();
            // Bias toward the shortcut paths and equal pairs.
            case ($urandom_range(7))
                0: r.b_den = r.a_den;
                1: r.a_den = 16'sd1;
                2: begin r.b_num = r.a_num; r.b_den = r.a_den; end
                default: ;
            endcase
            pending_reqs.push_back(r);
        end
        n_total = pending_reqs.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_reqs.size() == 0 && n_sent == n_total);
        wait (expected_rsps.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (n_errors == 0 && expected_rsps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
